>>> rtl/column_zscore_normalizer_assert.svh
// Assertion helpers included by the normalizer RTL
`ifndef COLUMN_ZSCORE_NORMALIZER_ASSERT_SVH
`define COLUMN_ZSCORE_NORMALIZER_ASSERT_SVH
// Property checked on every rising clock edge outside reset
`define CZN_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Condition must never hold outside reset
`define CZN_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`endif

>>> rtl/czn_pkg.sv
package czn_pkg;
  typedef enum logic [1:0] {
    KIND_NORM  = 2'd0,
    KIND_MEAN  = 2'd1,
    KIND_SIGMA = 2'd2
  } kind_e;

  typedef struct packed {
    logic        func;
    logic [31:0] sample;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  kind;
    logic [4:0]  row;
    logic        overflowed;
    logic        final_res;
  } out_item_t;
endpackage

>>> rtl/czn_ram.sv
module czn_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> rtl/column_zscore_normalizer.sv
// Z-score normalizer for one column of up to MAX_ROWS signed fixed-point
// samples with FRAC_BITS fraction bits. Loading accepts one item per cycle;
// stored samples live in one RAM with a registered read. On the closing
// item of a training column the block runs a sum pass, a 70-step mean
// division, a squared-deviation pass, a 70-step variance division, a
// 32-step square root, then per sample a read, a setup and a 70-step
// restoring division, and last the mean and sigma items. Test columns skip
// the statistics. Output stalls hold the sequence. No input item is taken
// while a column is being processed.
module column_zscore_normalizer #(
  parameter int MAX_ROWS  = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  czn_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output czn_pkg::out_item_t  out_data_o
);
  `include "column_zscore_normalizer_assert.svh"

  localparam int AW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_ROWS);

  typedef enum logic [3:0] {
    S_LOAD, S_SUM, S_MDIV, S_SQ, S_VDIV, S_SQRT, S_RD, S_NDIV, S_OUT,
    S_MOUT, S_SOUT
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   fill_q, ns_q, idx_q;
  logic            ovf_q, train_q, rd_vld_q;
  logic [31:0]     prev_q;
  logic signed [31:0] mean_q;
  logic [31:0]     sigma_q;
  logic signed [40:0] sum_q;
  logic [69:0]     sq_q;
  // shared restoring divider
  logic [69:0]     num_q;
  logic [31:0]     den_q;
  logic [69:0]     quo_q;
  logic [70:0]     rem_q;
  logic [6:0]      step_q;
  logic            neg_q;
  // square root
  logic [63:0]     sv_q, sres_q, sbit_q;
  logic [31:0]     ram_rd;
  logic [AW-1:0]   raddr;
  logic            we;
  logic [31:0]     wd;
  logic [AW-1:0]   wa;

  czn_ram #(.Width(32), .Depth(MAX_ROWS)) u_ram (
    .clk_i, .we_i(we), .waddr_i(wa), .wdata_i(wd), .raddr_i(raddr),
    .rdata_o(ram_rd)
  );

  assign in_stall_o = (state_q != S_LOAD);
  wire accept = in_valid_i && !in_stall_o;
  assign we = accept && (fill_q < MaxCnt);
  assign wa = fill_q[AW-1:0];
  assign wd = in_data_i.sample;
  assign raddr = idx_q[AW-1:0];

  wire signed [32:0] dev = $signed({ram_rd[31], ram_rd}) - $signed({mean_q[31], mean_q});
  wire [32:0] udev = dev[32] ? 33'(-dev) : 33'(dev);
  wire [65:0] sq = udev * udev;
  wire [70:0] rsh = {rem_q[69:0], num_q[69]};
  wire [70:0] rsub = rsh - {39'd0, den_q};
  wire [63:0] strial = sres_q + sbit_q;
  wire out_free = !out_valid_o || !out_stall_i;

  // Rounded magnitude quotient -> saturated signed value
  logic [31:0] sat_val;
  always_comb begin
    if (neg_q) sat_val = (quo_q > 70'h80000000) ? 32'h80000000 : 32'(-quo_q);
    else sat_val = (quo_q > 70'h7fffffff) ? 32'h7fffffff : quo_q[31:0];
  end

  // Sequence load, statistics, division and output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD; fill_q <= '0; ovf_q <= 1'b0; prev_q <= '0;
      out_valid_o <= 1'b0; rd_vld_q <= 1'b0; idx_q <= '0; ns_q <= '0;
      train_q <= 1'b0; step_q <= '0;
    end else begin
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      case (state_q)
        S_LOAD: if (accept) begin
          logic ovf_n;
          ovf_n = ovf_q || (fill_q >= MaxCnt);
          if (fill_q < MaxCnt) fill_q <= fill_q + 1'b1;
          ovf_q <= ovf_n;
          if (!in_data_i.last) begin
            prev_q <= in_data_i.sample;
          end else if (!in_data_i.func) begin
            train_q <= 1'b1;
            ns_q <= (fill_q < MaxCnt) ? fill_q + 1'b1 : fill_q;
            idx_q <= '0; rd_vld_q <= 1'b0; sum_q <= '0; state_q <= S_SUM;
          end else begin
            train_q <= 1'b0;
            mean_q <= prev_q; sigma_q <= in_data_i.sample;
            idx_q <= '0; rd_vld_q <= 1'b0;
            if (fill_q >= MaxCnt) begin
              ns_q <= ovf_q ? MaxCnt : MaxCnt - 1'b1; state_q <= S_RD;
            end else if (fill_q + 1'b1 < CW'(3)) begin
              fill_q <= '0; ovf_q <= 1'b0; prev_q <= '0;
            end else begin
              ns_q <= fill_q - 1'b1; state_q <= S_RD;
            end
          end
        end
        S_SUM: begin
          rd_vld_q <= (idx_q < ns_q);
          if (idx_q < ns_q) idx_q <= idx_q + 1'b1;
          if (rd_vld_q) sum_q <= sum_q + 41'($signed(ram_rd));
          else if (idx_q != '0) begin
            neg_q <= sum_q[40];
            num_q <= 70'(sum_q[40] ? -sum_q : sum_q) + 70'(ns_q >> 1);
            den_q <= 32'(ns_q); quo_q <= '0; rem_q <= '0; step_q <= 7'd70;
            state_q <= S_MDIV;
          end
        end
        S_MDIV, S_VDIV, S_NDIV: begin
          if (step_q != 0) begin
            if (!rsub[70]) begin rem_q <= rsub; quo_q <= {quo_q[68:0], 1'b1}; end
            else begin rem_q <= rsh; quo_q <= {quo_q[68:0], 1'b0}; end
            num_q <= {num_q[68:0], 1'b0};
            step_q <= step_q - 1'b1;
          end else if (state_q == S_MDIV) begin
            mean_q <= neg_q ? 32'(-quo_q) : quo_q[31:0];
            idx_q <= '0; rd_vld_q <= 1'b0; sq_q <= '0; state_q <= S_SQ;
          end else if (state_q == S_VDIV) begin
            sv_q <= quo_q[63:0]; sres_q <= '0; sbit_q <= 64'h4000000000000000;
            state_q <= S_SQRT;
          end else if (out_free) begin
            out_valid_o <= 1'b1;
            out_data_o <= '{sat_val, czn_pkg::KIND_NORM, 5'(idx_q - 1'b1), ovf_q,
                            !train_q && (idx_q == ns_q)};
            state_q <= S_RD;
          end
        end
        S_SQ: begin
          rd_vld_q <= (idx_q < ns_q);
          if (idx_q < ns_q) idx_q <= idx_q + 1'b1;
          if (rd_vld_q) sq_q <= sq_q + 70'(sq);
          else if (idx_q != '0) begin
            num_q <= sq_q; den_q <= 32'(ns_q); quo_q <= '0; rem_q <= '0;
            step_q <= 7'd70; state_q <= S_VDIV;
          end
        end
        S_SQRT: begin
          if (sbit_q != 0) begin
            if (sv_q >= strial) begin
              sv_q <= sv_q - strial; sres_q <= (sres_q >> 1) + sbit_q;
            end else sres_q <= sres_q >> 1;
            sbit_q <= sbit_q >> 2;
          end else begin
            sigma_q <= (sres_q > 64'h7fffffff) ? 32'h7fffffff : sres_q[31:0];
            idx_q <= '0; rd_vld_q <= 1'b0; state_q <= S_RD;
          end
        end
        S_RD: begin
          // issue read of idx; S_OUT then sets up the division
          if (idx_q == ns_q) begin
            state_q <= train_q ? S_MOUT : S_LOAD;
            if (!train_q) begin fill_q <= '0; ovf_q <= 1'b0; prev_q <= '0; end
          end else begin
            idx_q <= idx_q + 1'b1; state_q <= S_OUT;
          end
        end
        S_OUT: begin
          logic [31:0] us;
          us = sigma_q[31] ? 32'(-sigma_q) : sigma_q;
          neg_q <= dev[32] ^ sigma_q[31];
          num_q <= (70'(udev) << FRAC_BITS) + 70'(us >> 1);
          den_q <= us; quo_q <= '0; rem_q <= '0;
          step_q <= (sigma_q == 0) ? 7'd0 : 7'd70;
          state_q <= S_NDIV;
        end
        S_MOUT: if (out_free) begin
          out_valid_o <= 1'b1;
          out_data_o <= '{mean_q, czn_pkg::KIND_MEAN, 5'd0, ovf_q, 1'b0};
          state_q <= S_SOUT;
        end
        S_SOUT: if (out_free) begin
          out_valid_o <= 1'b1;
          out_data_o <= '{sigma_q, czn_pkg::KIND_SIGMA, 5'd0, ovf_q, 1'b1};
          fill_q <= '0; ovf_q <= 1'b0; prev_q <= '0; state_q <= S_LOAD;
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  `CZN_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= MaxCnt)
  `CZN_ASSERT(a_hold_out, clk_i, rst_ni,
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
  `CZN_NEVER(a_no_write_busy, clk_i, rst_ni, we && (state_q != S_LOAD))
endmodule

>>> tb/column_zscore_normalizer_tb.sv
`timescale 1ns / 1ps

module column_zscore_normalizer_tb;

  localparam int MAX_ROWS  = 32;
  localparam int FRAC_BITS = 16;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam int WATCHDOG_LIMIT = 20000;

  localparam logic FUNC_TRAIN = 1'b0;
  localparam logic FUNC_TEST  = 1'b1;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  czn_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  czn_pkg::out_item_t out_data_o;

  column_zscore_normalizer #(
    .MAX_ROWS (MAX_ROWS),
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Column state of the predictor
  logic [31:0] col_store [MAX_ROWS];
  int unsigned col_fill;
  bit          col_ovf;
  logic [31:0] col_prev;

  czn_pkg::out_item_t expected_q [$];
  int          error_count;
  int          items_sent;
  int          results_seen;
  int          columns_sent;
  int          idle_cycles;
  bit          quiet_mode;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic longint sx(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // (d << FRAC_BITS) / s, rounded half away from zero, saturated
  function automatic longint scaled_div(longint d, longint s);
    bit neg;
    logic [127:0] ud, us, q;
    neg = (d < 0) != (s < 0);
    ud  = d < 0 ? -d : d;
    us  = s < 0 ? -s : s;
    q   = ((ud << FRAC_BITS) + us / 2) / us;
    if (neg) return q > 128'd2147483648 ? S32_MIN : -longint'(q);
    return q > 128'(S32_MAX) ? S32_MAX : longint'(q);
  endfunction

  function automatic void push_result(longint v, czn_pkg::kind_e k, int unsigned r,
                                      bit ovf, bit fin);
    czn_pkg::out_item_t o;
    o.value      = v[31:0];
    o.kind       = k;
    o.row        = r[4:0];
    o.overflowed = ovf;
    o.final_res  = fin;
    expected_q.push_back(o);
  endfunction

  // Advance the column state by one item and queue the results it causes
  function automatic void predict_column(czn_pkg::in_item_t it);
    bit dropped, prior;
    int unsigned n, ns;
    longint sum, mean, sigma, v, d;
    logic [127:0] sq_sum;
    longint unsigned var_q;
    prior   = col_ovf;
    dropped = 1'b0;
    if (col_fill < MAX_ROWS) begin
      col_store[col_fill] = it.sample;
      col_fill++;
    end else begin
      col_ovf = 1'b1;
      dropped = 1'b1;
    end
    if (!it.last) begin
      col_prev = it.sample;
      return;
    end
    if (it.func == FUNC_TRAIN) begin
      n   = col_fill;
      sum = 0;
      for (int r = 0; r < n; r++) sum += sx(col_store[r]);
      if (sum >= 0) mean = (sum + n / 2) / n;
      else mean = -((-sum + n / 2) / n);
      sq_sum = 0;
      for (int r = 0; r < n; r++) begin
        d = sx(col_store[r]) - mean;
        if (d < 0) d = -d;
        sq_sum += 128'(d) * 128'(d);
      end
      var_q = 64'(sq_sum / n);
      sigma = longint'(int_sqrt(var_q));
      if (sigma > S32_MAX) sigma = S32_MAX;
      for (int r = 0; r < n; r++) begin
        v = sigma == 0 ? 0 : scaled_div(sx(col_store[r]) - mean, sigma);
        push_result(v, czn_pkg::KIND_NORM, r, col_ovf, 1'b0);
      end
      push_result(mean, czn_pkg::KIND_MEAN, 0, col_ovf, 1'b0);
      push_result(sigma, czn_pkg::KIND_SIGMA, 0, col_ovf, 1'b1);
    end else begin
      mean  = sx(col_prev);
      sigma = sx(it.sample);
      if (!dropped) ns = col_fill < 3 ? 0 : col_fill - 2;
      else ns = prior ? MAX_ROWS : MAX_ROWS - 1;
      for (int r = 0; r < ns; r++) begin
        v = sigma == 0 ? 0 : scaled_div(sx(col_store[r]) - mean, sigma);
        push_result(v, czn_pkg::KIND_NORM, r, col_ovf, r + 1 == ns);
      end
    end
    col_fill = 0;
    col_ovf  = 1'b0;
    col_prev = '0;
  endfunction

  task automatic report_mismatch(string what, czn_pkg::out_item_t got,
                                 czn_pkg::out_item_t want);
    error_count++;
    $display("MISMATCH %s: got val=%h kind=%0d row=%0d ovf=%0b fin=%0b, %s",
             what, got.value, got.kind, got.row, got.overflowed, got.final_res,
             $sformatf("want val=%h kind=%0d row=%0d ovf=%0b fin=%0b",
                       want.value, want.kind, want.row, want.overflowed,
                       want.final_res));
  endtask

  // Send one item, idling first at random, and predict it once it is taken
  task automatic send_item(logic f, logic [31:0] s, logic l);
    czn_pkg::in_item_t it;
    it.func   = f;
    it.sample = s;
    it.last   = l;
    while (!quiet_mode && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_column(it);
    items_sent++;
    if (l) columns_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_column(logic f, int len, int mode);
    logic [31:0] s;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: s = $urandom;
        1: s = $urandom_range(32'h0008_0000) - 32'h0004_0000;
        default: s = {{8{1'($urandom_range(1))}}, 24'($urandom)};
      endcase
      if (f == FUNC_TEST && i == len - 1) s = $urandom_range(3) == 0 ? 32'd0 :
                                             32'($urandom_range(32'h0004_0000, 1));
      send_item(f, s, i == len - 1);
    end
  endtask

  // Directed column table: func, sample, last
  typedef struct {
    logic        f;
    logic [31:0] s;
    logic        l;
  } stim_row_t;

  stim_row_t dir_rows [] = '{
    '{FUNC_TRAIN, 32'h7FFF_FFFF, 1'b0}, '{FUNC_TRAIN, 32'h8000_0000, 1'b1},
    '{FUNC_TRAIN, 32'h0001_0000, 1'b0}, '{FUNC_TRAIN, 32'h0001_0000, 1'b0},
    '{FUNC_TRAIN, 32'h0001_0000, 1'b1},
    '{FUNC_TRAIN, 32'h0003_0000, 1'b0}, '{FUNC_TRAIN, 32'hFFFD_0000, 1'b1},
    '{FUNC_TEST,  32'h0005_0000, 1'b0}, '{FUNC_TEST,  32'hFFFF_FFFF, 1'b0},
    '{FUNC_TEST,  32'h0001_0000, 1'b0}, '{FUNC_TEST,  32'h0002_0000, 1'b1},
    '{FUNC_TEST,  32'h7FFF_FFFF, 1'b0}, '{FUNC_TEST,  32'h0000_0000, 1'b0},
    '{FUNC_TEST,  32'h0000_0001, 1'b1},
    '{FUNC_TEST,  32'h1234_5678, 1'b0}, '{FUNC_TEST,  32'h0000_0000, 1'b1},
    '{FUNC_TEST,  32'h0000_0010, 1'b1},
    '{FUNC_TEST,  32'h0000_0004, 1'b0}, '{FUNC_TEST,  32'h0000_0000, 1'b0},
    '{FUNC_TEST,  32'h0000_0000, 1'b1},
    '{FUNC_TRAIN, 32'h0000_0042, 1'b1}
  };

  // Output side: stall at random and check each result
  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= !quiet_mode && $urandom_range(99) < 8;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_data_o, '0);
      end else begin
        czn_pkg::out_item_t want;
        want = expected_q.pop_front();
        if (out_data_o !== want) report_mismatch("field", out_data_o, want);
      end
    end
  end

  // Watchdog on cycles without any accepted item or result
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d results still expected", expected_q.size());
      $display("column_zscore_normalizer_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int wait_cnt;
    czn_pkg::out_item_t hand_mean, hand_sigma;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    error_count = 0;
    items_sent  = 0;
    results_seen = 0;
    columns_sent = 0;
    quiet_mode  = 1'b0;
    col_fill    = 0;
    col_ovf     = 1'b0;
    col_prev    = '0;
    hand_mean   = '{32'hFFFF_FFFF, czn_pkg::KIND_MEAN, 5'd0, 1'b0, 1'b0};
    hand_sigma  = '{32'h7FFF_FFFF, czn_pkg::KIND_SIGMA, 5'd0, 1'b0, 1'b1};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows; the first column is the two extremes, mean -1, sigma 2^31-1
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].f, dir_rows[i].s, dir_rows[i].l);
      if (i == 1) begin
        if (expected_q.size() != 4) begin
          report_mismatch("extreme column size", '0, hand_mean);
        end else begin
          if (expected_q[2] !== hand_mean)
            report_mismatch("extreme column mean", expected_q[2], hand_mean);
          if (expected_q[3] !== hand_sigma)
            report_mismatch("extreme column sigma", expected_q[3], hand_sigma);
        end
      end
    end

    // Overflowing columns: train, test with only closing dropped, test fully over
    send_column(FUNC_TRAIN, MAX_ROWS + 3, 1);
    send_column(FUNC_TEST, MAX_ROWS + 1, 1);
    send_column(FUNC_TEST, MAX_ROWS + 4, 2);

    // Random columns, mostly short; recurring stretches without idling
    while (items_sent < 320) begin
      int len, mode;
      quiet_mode = columns_sent % 12 >= 9;
      len  = $urandom_range(99) < 6 ? $urandom_range(MAX_ROWS + 4, MAX_ROWS - 1) :
             $urandom_range(8, 1);
      mode = $urandom_range(2);
      send_column(1'($urandom_range(1)), len, mode);
    end
    in_valid_i <= 1'b0;
    quiet_mode = 1'b0;

    wait_cnt = 0;
    while (expected_q.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (200) @(posedge clk_i);
    $display("covered %0d items in %0d columns, %0d results checked", items_sent,
             columns_sent, results_seen);
    $display("columns included saturation, zero sigma, short test and overflow cases");
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("column_zscore_normalizer_tb: done, clean");
    end else begin
      $display("%0d mismatches, %0d results missing", error_count, expected_q.size());
      $display("column_zscore_normalizer_tb: done, errors");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl
rtl/czn_pkg.sv
rtl/czn_ram.sv
rtl/column_zscore_normalizer.sv
tb/column_zscore_normalizer_tb.sv
